FILE: rtl/utld_pkg.sv
// Package for the UTC to local time offset block.
// Holds the word types, calendar constants and the month length function.
// No dependencies.
package utld_pkg;

    localparam logic [4:0]  OFFSET_RESET    = 5'd8;
    localparam logic [5:0]  HOURS_PER_DAY   = 6'd24;
    localparam logic [4:0]  MONTHS_PER_YEAR = 5'd12;
    localparam logic [4:0]  LEAP_FEB_DAYS   = 5'd29;
    localparam logic [3:0]  MONTH_FEB       = 4'd2;

    // Divisibility by 25: y * inverse(25) mod 2^16 is at most 65535 / 25
    localparam logic [15:0] INV25_MOD16     = 16'd23593;
    localparam logic [15:0] MAX_Q25         = 16'd2621;

    typedef struct packed {
        logic        has_fix;
        logic [15:0] src_year;
        logic [3:0]  src_month;
        logic [4:0]  src_day;
        logic [4:0]  src_hour;
        logic [5:0]  src_minute;
        logic [5:0]  src_second;
    } t_in_word;

    typedef struct packed {
        logic        converted;
        logic [15:0] local_year;
        logic [3:0]  local_month;
        logic [4:0]  local_day;
        logic [4:0]  local_hour;
        logic [5:0]  local_minute;
        logic [5:0]  local_second;
    } t_out_word;

    function automatic logic [4:0] days_of(input logic leap, input logic [3:0] month);
        logic [4:0] len;
        begin
            unique case (month)
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
                4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
                MONTH_FEB:                                  len = leap ? LEAP_FEB_DAYS
                                                                       : 5'd28;
                default:                                    len = 5'd31;
            endcase
            return len;
        end
    endfunction

endpackage

FILE: rtl/utld_in_if.sv
// Input channel interface: valid/ready handshake with one UTC time word.
// Depends on utld_pkg.
interface utld_in_if;
    logic               valid;
    logic               ready;
    utld_pkg::t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/utld_out_if.sv
// Output channel interface: valid/ready handshake with one local time word.
// Depends on utld_pkg.
interface utld_out_if;
    logic                valid;
    logic                ready;
    utld_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/utld_roll.sv
// Calendar rollover logic: adds the hour offset and carries into day, month, year.
// Purely combinational. Depends on utld_pkg.
module utld_roll (
    input  utld_pkg::t_in_word  i_word,
    input  logic [4:0]          i_offset,
    output logic [15:0]         o_year,
    output logic [3:0]          o_month,
    output logic [4:0]          o_day,
    output logic [4:0]          o_hour
);
    import utld_pkg::*;

    logic [5:0]  hour_sum;
    logic [5:0]  hour_once;
    logic [5:0]  hour_twice;
    logic        day_roll;
    logic [15:0] q25;
    logic        div25;
    logic        leap;
    logic [4:0]  dim;
    logic [5:0]  day_inc;
    logic        month_roll;
    logic [4:0]  month_inc;

    always_comb begin
        hour_sum   = {1'b0, i_word.src_hour} + {1'b0, i_offset};
        day_roll   = hour_sum >= HOURS_PER_DAY;
        hour_once  = hour_sum - HOURS_PER_DAY;
        hour_twice = (hour_once >= HOURS_PER_DAY) ? (hour_once - HOURS_PER_DAY) : hour_once;

        q25   = i_word.src_year * INV25_MOD16;
        div25 = q25 <= MAX_Q25;
        leap  = ((i_word.src_year[1:0] == 2'd0) && !div25)
              || ((i_word.src_year[3:0] == 4'd0) && div25);
        dim   = days_of(leap, i_word.src_month);

        day_inc    = {1'b0, i_word.src_day} + 6'd1;
        month_roll = day_inc > {1'b0, dim};
        month_inc  = {1'b0, i_word.src_month} + 5'd1;

        o_year  = i_word.src_year;
        o_month = i_word.src_month;
        o_day   = i_word.src_day;
        o_hour  = hour_sum[4:0];
        if (day_roll) begin
            o_hour = hour_twice[4:0];
            o_day  = day_inc[4:0];
            if (month_roll) begin
                o_day = 5'(day_inc - {1'b0, dim});
                if (month_inc > MONTHS_PER_YEAR) begin
                    o_month = 4'd1;
                    o_year  = i_word.src_year + 16'd1;
                end else begin
                    o_month = month_inc[3:0];
                end
            end
        end
    end

endmodule

FILE: rtl/utc_to_local_time_offset.sv
// Top level of the UTC to local time offset block.
// Depends on utld_pkg, utld_in_if, utld_out_if and utld_roll.
//
// Usage:
//   i_in carries UTC time words with a fix flag; o_out carries one local time
//   word for every input word, in order. A word with the fix flag set is
//   converted with the offset in the configuration register and becomes the
//   held time; a word without a fix repeats the held time with converted clear.
//   i_cfg_we / i_cfg_wdata write the hour offset; write only while idle.
// Timing:
//   o_out.valid rises once the accepted word has passed one input register,
//   then the rollover logic into the output register, which also holds the
//   local time. One word per cycle is sustained while o_out.ready is high.
// Reset (i_rst_n, synchronous): offset returns to 8, held time to all zeros,
//   both pipeline stages empty.
// Stall: when o_out.ready is low the output word holds, the input register
//   still fills once, and i_in.ready drops only when both stages are full.
module utc_to_local_time_offset (
    input  logic             i_clk,
    input  logic             i_rst_n,
    utld_in_if.sink          i_in,
    utld_out_if.source       o_out,
    input  logic             i_cfg_we,
    input  logic [4:0]       i_cfg_wdata
);
    import utld_pkg::*;

    logic [4:0] r_offset_hours;
    logic       r_s1_valid;
    t_in_word   r_s1_word;
    logic       r_out_valid;
    t_out_word  r_out_word;
    t_out_word  n_out_word;
    logic       s1_advance;
    logic [15:0] roll_year;
    logic [3:0]  roll_month;
    logic [4:0]  roll_day;
    logic [4:0]  roll_hour;

    assign s1_advance = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_s1_valid || s1_advance;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_word;

    utld_roll u_roll (
        .i_word   (r_s1_word),
        .i_offset (r_offset_hours),
        .o_year   (roll_year),
        .o_month  (roll_month),
        .o_day    (roll_day),
        .o_hour   (roll_hour)
    );

    always_comb begin
        n_out_word           = r_out_word;
        n_out_word.converted = r_s1_word.has_fix;
        if (r_s1_word.has_fix) begin
            n_out_word.local_year   = roll_year;
            n_out_word.local_month  = roll_month;
            n_out_word.local_day    = roll_day;
            n_out_word.local_hour   = roll_hour;
            n_out_word.local_minute = r_s1_word.src_minute;
            n_out_word.local_second = r_s1_word.src_second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_hours <= OFFSET_RESET;
        end else if (i_cfg_we) begin
            r_offset_hours <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_s1_word <= i_in.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_word  <= '0;
        end else if (s1_advance) begin
            r_out_valid <= r_s1_valid;
            if (r_s1_valid) begin
                r_out_word <= n_out_word;
            end
        end
    end

endmodule

FILE: tb/testbench.sv
// Testbench for utc_to_local_time_offset: drives UTC time words, predicts local time.
// Depends on utld_pkg, utld_in_if, utld_out_if and the block itself.
// Self-checking: expected words are queued at input acceptance and compared at output.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import utld_pkg::*;

    localparam int unsigned LONG_HOLD   = 80;
    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned MAX_PRINTS  = 50;
    localparam int unsigned MONTH_APR   = 4;
    localparam int unsigned MONTH_JUN   = 6;
    localparam int unsigned MONTH_SEP   = 9;
    localparam int unsigned MONTH_NOV   = 11;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [4:0] i_cfg_wdata;

    utld_in_if  in_ch ();
    utld_out_if out_ch ();

    utc_to_local_time_offset u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    t_in_word    utc_pending[$];
    t_out_word   local_time_due[$];
    t_out_word   held_local = '0;
    logic [4:0]  zone_offset = OFFSET_RESET;
    int unsigned mismatch_count = 0;
    int unsigned send_gap = 0;
    int unsigned recv_gap = 0;
    int unsigned hold_left = 0;
    int unsigned stall_req = 0;
    int unsigned stall_served = 0;
    int unsigned quiet_cycles = 0;
    bit          calm = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_out_word to_local_time(input t_in_word w);
        int unsigned yr;
        int unsigned mo;
        int unsigned dy;
        int unsigned hr;
        int unsigned span;
        logic        leap;
        t_out_word   res;
        if (w.has_fix) begin
            yr = w.src_year;
            mo = w.src_month;
            dy = w.src_day;
            hr = w.src_hour + zone_offset;
            if (hr >= HOURS_PER_DAY) begin
                hr -= HOURS_PER_DAY;
                if (hr >= HOURS_PER_DAY) hr -= HOURS_PER_DAY;
                dy += 1;
                leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
                case (mo)
                    MONTH_FEB: span = leap ? LEAP_FEB_DAYS : 28;
                    MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: span = 30;
                    default: span = 31;
                endcase
                if (dy > span) begin
                    dy -= span;
                    mo += 1;
                    if (mo > MONTHS_PER_YEAR) begin
                        mo = 1;
                        yr = (yr + 1) & 16'hFFFF;
                    end
                end
            end
            held_local.local_year   = yr[15:0];
            held_local.local_month  = mo[3:0];
            held_local.local_day    = dy[4:0];
            held_local.local_hour   = hr[4:0];
            held_local.local_minute = w.src_minute;
            held_local.local_second = w.src_second;
        end
        res = held_local;
        res.converted = w.has_fix;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    endtask

    task automatic check_local_time(input t_out_word got, input t_out_word want);
        if (got.converted != want.converted)
            report_mismatch("converted", got.converted, want.converted);
        if (got.local_year != want.local_year)
            report_mismatch("local_year", got.local_year, want.local_year);
        if (got.local_month != want.local_month)
            report_mismatch("local_month", got.local_month, want.local_month);
        if (got.local_day != want.local_day)
            report_mismatch("local_day", got.local_day, want.local_day);
        if (got.local_hour != want.local_hour)
            report_mismatch("local_hour", got.local_hour, want.local_hour);
        if (got.local_minute != want.local_minute)
            report_mismatch("local_minute", got.local_minute, want.local_minute);
        if (got.local_second != want.local_second)
            report_mismatch("local_second", got.local_second, want.local_second);
    endtask

    // Driver: offer pending words, hold while stalled, insert idle bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                local_time_due.push_back(to_local_time(in_ch.data));
            if (in_ch.valid && !in_ch.ready) begin
            end else if (send_gap > 0) begin
                send_gap--;
                in_ch.valid <= 1'b0;
            end else if (utc_pending.size() > 0) begin
                in_ch.valid <= 1'b1;
                in_ch.data  <= utc_pending.pop_front();
                if (!calm && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 18);
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each output word, drive ready with bursts and long holds.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            recv_gap = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (local_time_due.size() == 0)
                    report_mismatch("unexpected word", out_ch.data.local_hour, 0);
                else
                    check_local_time(out_ch.data, local_time_due.pop_front());
            end
            if (stall_req != stall_served) begin
                stall_served = stall_req;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                if (!calm && $urandom_range(0, 9) == 0) recv_gap = $urandom_range(1, 18);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles", quiet_cycles);
                $display("testbench: errors");
                $finish;
            end
        end
    end

    task automatic push_utc(input logic fix, input int unsigned yr, input int unsigned mo,
                            input int unsigned dy, input int unsigned hr,
                            input int unsigned mi, input int unsigned se);
        t_in_word w;
        w.has_fix    = fix;
        w.src_year   = yr[15:0];
        w.src_month  = mo[3:0];
        w.src_day    = dy[4:0];
        w.src_hour   = hr[4:0];
        w.src_minute = mi[5:0];
        w.src_second = se[5:0];
        utc_pending.push_back(w);
    endtask

    task automatic queue_random(input int unsigned count);
        int unsigned years[8] = '{1900, 2000, 2100, 2400, 0, 65535, 2023, 2024};
        int unsigned yr;
        int unsigned mo;
        int unsigned dy;
        int unsigned hr;
        int unsigned mi;
        int unsigned se;
        int unsigned cap;
        repeat (count) begin
            yr = ($urandom_range(0, 2) == 0) ? years[$urandom_range(0, 7)]
                                             : $urandom_range(0, 65535);
            if ($urandom_range(0, 7) == 0) begin
                mo = $urandom_range(0, 15);
                dy = $urandom_range(0, 31);
            end else begin
                mo = $urandom_range(1, 12);
                cap = (mo == MONTH_FEB) ? 29 :
                      (mo == MONTH_APR || mo == MONTH_JUN ||
                       mo == MONTH_SEP || mo == MONTH_NOV) ? 30 : 31;
                dy = $urandom_range(0, 1) ? $urandom_range(cap - 3, cap)
                                          : $urandom_range(1, cap);
            end
            case ($urandom_range(0, 7))
                0:       hr = $urandom_range(24, 31);
                1, 2, 3: hr = $urandom_range(14, 23);
                default: hr = $urandom_range(0, 23);
            endcase
            mi = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 59);
            se = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 60);
            push_utc($urandom_range(0, 9) != 0, yr, mo, dy, hr, mi, se);
        end
    endtask

    task automatic wait_drained();
        while (utc_pending.size() != 0 || local_time_due.size() != 0 || in_ch.valid)
            @(posedge i_clk);
    endtask

    task automatic write_offset(input logic [4:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        zone_offset = value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset offset of 8 hours
        push_utc(1'b0, 65535, 15, 31, 31, 63, 63);
        push_utc(1'b1, 2023, 12, 31, 20, 15, 30);
        push_utc(1'b1, 65535, 12, 31, 23, 59, 59);
        push_utc(1'b1, 2024, 2, 28, 16, 0, 0);
        push_utc(1'b1, 2024, 2, 29, 23, 1, 2);
        push_utc(1'b1, 2023, 2, 28, 23, 3, 4);
        push_utc(1'b1, 1900, 2, 28, 23, 5, 6);
        push_utc(1'b1, 2000, 2, 28, 23, 7, 8);
        push_utc(1'b1, 2021, 4, 30, 20, 9, 10);
        push_utc(1'b1, 2021, 6, 15, 0, 11, 12);
        push_utc(1'b1, 2021, 7, 15, 15, 13, 14);
        push_utc(1'b1, 2021, 7, 31, 16, 15, 16);
        push_utc(1'b0, 0, 1, 1, 0, 0, 0);
        push_utc(1'b1, 2022, 5, 10, 31, 17, 18);
        push_utc(1'b1, 2022, 0, 31, 23, 19, 20);
        push_utc(1'b1, 2022, 15, 10, 23, 21, 22);
        push_utc(1'b1, 2022, 13, 31, 20, 23, 24);
        push_utc(1'b1, 2022, 3, 0, 23, 25, 26);
        push_utc(1'b1, 2022, 3, 0, 2, 27, 28);
        push_utc(1'b1, 2023, 2, 31, 23, 29, 30);
        push_utc(1'b1, 2023, 8, 8, 8, 63, 63);
        push_utc(1'b1, 2023, 9, 30, 10, 0, 60);
        push_utc(1'b1, 0, 0, 0, 0, 0, 0);
        push_utc(1'b0, 65535, 15, 31, 31, 63, 63);
        wait_drained();

        write_offset(5'd0);
        queue_random(80);
        wait_drained();

        write_offset(5'd23);
        stall_req++;
        queue_random(100);
        wait_drained();

        write_offset(5'd31);
        push_utc(1'b1, 2024, 12, 31, 31, 59, 59);
        push_utc(1'b1, 2024, 2, 28, 0, 0, 0);
        push_utc(1'b1, 2024, 11, 30, 24, 1, 1);
        queue_random(100);
        wait_drained();

        write_offset(5'($urandom_range(0, 31)));
        queue_random(100);
        wait_drained();

        write_offset(5'd1);
        queue_random(120);
        wait_drained();

        calm = 1'b1;
        write_offset(5'($urandom_range(16, 23)));
        queue_random(200);
        wait_drained();
        repeat (4) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
